/* src/sbc_pkg.sv */
// Shared constants and types for the swept box collision core.
package sbc_pkg;

  localparam int unsigned CoordWidthDef   = 16;
  localparam int unsigned TimeFracBitsDef = 16;

  // Flags that ride along with an item through the entry time divider.
  typedef struct packed {
    logic       hit;
    logic [1:0] normal_x;
    logic [1:0] normal_y;
  } sbc_side_t;

endpackage

/* src/swept_box_collision_core.sv */
// Top level of the swept box collision core: slab setup, compares, divider.
//
// Usage: one box pair enters per item on the s_axis channel; one result item
// leaves on m_axis for each input item, in order. A moving box A (left/top,
// size, per-frame displacement) is tested against a static box B with the
// slab method; the result gives a hit flag, the entry time as an unsigned
// fraction and the contact normal (zero on a tie or a miss).
// Throughput: one item per cycle while the output is not stalled. Pipeline:
// three stages for slab setup, cross products and compares, then one stage
// per quotient bit of the entry time divider.
// Stall: the whole pipeline advances only when its last stage is empty or
// taken, so s_axis_tready follows m_axis_tready and the output register
// holds a result until it is taken; nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits; the pipeline comes up empty and ready.
module swept_box_collision_core import sbc_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = CoordWidthDef,
  parameter int unsigned TIME_FRAC_BITS = TimeFracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // box_a_x, box_a_y, box_a_w, box_a_h, vel_x, vel_y, box_b_x, box_b_y, box_b_w, box_b_h
  input  logic [((10*COORD_WIDTH-4+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit, entry_time, normal_x, normal_y
  output logic [((TIME_FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 2;       // slab distances
  localparam int unsigned PW = DW + W + 1;  // cross products
  localparam int unsigned IW = ((10*W-4+7)/8)*8;
  localparam int unsigned OW = ((TIME_FRAC_BITS+5+7)/8)*8;

  logic en;
  logic div_valid;
  logic [TIME_FRAC_BITS-1:0] div_quot;
  sbc_side_t div_side;

  assign en            = !div_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack fields.
  logic signed [W-1:0] ax, ay, vx, vy, bx, by;
  logic [W-2:0]        aw, ah, bw, bh;
  assign ax = s_axis_tdata[0*W +: W];
  assign ay = s_axis_tdata[1*W +: W];
  assign aw = s_axis_tdata[2*W +: W-1];
  assign ah = s_axis_tdata[3*W-1 +: W-1];
  assign vx = s_axis_tdata[4*W-2 +: W];
  assign vy = s_axis_tdata[5*W-2 +: W];
  assign bx = s_axis_tdata[6*W-2 +: W];
  assign by = s_axis_tdata[7*W-2 +: W];
  assign bw = s_axis_tdata[8*W-2 +: W-1];
  assign bh = s_axis_tdata[9*W-3 +: W-1];

  // Stage 1: per axis entry/exit fractions. Index 0 is x, 1 is y.
  logic                 s1_valid_q;
  logic signed [DW-1:0] s1_nn_q [2], s1_fn_q [2];
  logic [W-1:0]         s1_den_q [2];
  logic                 s1_inf_q [2], s1_ok_q [2], s1_neg_q [2];

  logic signed [DW-1:0] s1_nn_d [2], s1_fn_d [2];
  logic [W-1:0]         s1_den_d [2];
  logic                 s1_inf_d [2], s1_ok_d [2], s1_neg_d [2];

  always_comb begin
    logic signed [DW-1:0] a, v, b, asz, bsz, dn, df;
    for (int k = 0; k < 2; k++) begin
      a   = (k == 0) ? DW'(ax) : DW'(ay);
      b   = (k == 0) ? DW'(bx) : DW'(by);
      v   = (k == 0) ? DW'(vx) : DW'(vy);
      asz = (k == 0) ? DW'({1'b0, aw}) : DW'({1'b0, ah});
      bsz = (k == 0) ? DW'({1'b0, bw}) : DW'({1'b0, bh});
      dn  = b - a - asz;
      df  = b + bsz - a;
      s1_neg_d[k] = v < 0;
      s1_inf_d[k] = v == 0;
      s1_ok_d[k]  = 1'b1;
      if (v > 0) begin
        s1_nn_d[k]  = dn;
        s1_fn_d[k]  = df;
        s1_den_d[k] = v[W-1:0];
      end else if (v < 0) begin
        s1_nn_d[k]  = -df;
        s1_fn_d[k]  = -dn;
        s1_den_d[k] = W'(-v);
      end else begin
        s1_ok_d[k]  = (dn <= 0) && (df >= 0);
        s1_nn_d[k]  = -DW'(1);
        s1_fn_d[k]  = DW'(1);
        s1_den_d[k] = '0;
      end
    end
  end

  // Stage 2: cross products for every compare.
  logic                 s2_valid_q;
  logic signed [DW-1:0] s2_nn_q [2], s2_fn_q [2];
  logic [W-1:0]         s2_den_q [2];
  logic                 s2_inf_q [2], s2_ok_q [2], s2_neg_q [2];
  // nx*fy.den, fy*nx.den, ny*fx.den, fx*ny.den, nx*ny.den, ny*nx.den, fx*fy.den, fy*fx.den
  logic signed [PW-1:0] s2_p_q [8];

  function automatic logic signed [PW-1:0] xmul(logic signed [DW-1:0] n, logic [W-1:0] d);
    return PW'(n * $signed({1'b0, d}));
  endfunction

  // Stage 3: compares, selection of the entry time, normal.
  logic            s3_valid_q;
  sbc_side_t       s3_side_q;
  logic [W-1:0]    s3_num_q, s3_den_q;

  // Three-way compare of two slab fractions; returns -1, 0 or 1.
  function automatic logic signed [1:0] fcmp(logic ia, logic signed [DW-1:0] na, logic ib,
                                             logic signed [DW-1:0] nb,
                                             logic signed [PW-1:0] l,
                                             logic signed [PW-1:0] r);
    logic signed [2:0] ra, rb;
    ra = ia ? ((na < 0) ? -3'sd2 : 3'sd2) : 3'sd0;
    rb = ib ? ((nb < 0) ? -3'sd2 : 3'sd2) : 3'sd0;
    if (ra != rb) return (ra < rb) ? -2'sd1 : 2'sd1;
    if (ra != 0)  return 2'sd0;
    if (l == r)   return 2'sd0;
    return (l < r) ? -2'sd1 : 2'sd1;
  endfunction

  sbc_side_t    s3_side_d;
  logic [W-1:0] s3_num_d, s3_den_d;

  always_comb begin
    logic signed [1:0] c_nf, c_fn, c, cf;
    logic signed [DW-1:0] tn, fn;
    logic [W-1:0] td;
    logic ti, fi, hit;
    c_nf = fcmp(s2_inf_q[0], s2_nn_q[0], s2_inf_q[1], s2_fn_q[1], s2_p_q[0], s2_p_q[1]);
    c_fn = fcmp(s2_inf_q[1], s2_nn_q[1], s2_inf_q[0], s2_fn_q[0], s2_p_q[2], s2_p_q[3]);
    c    = fcmp(s2_inf_q[0], s2_nn_q[0], s2_inf_q[1], s2_nn_q[1], s2_p_q[4], s2_p_q[5]);
    cf   = fcmp(s2_inf_q[0], s2_fn_q[0], s2_inf_q[1], s2_fn_q[1], s2_p_q[6], s2_p_q[7]);
    tn = (c >= 0) ? s2_nn_q[0]  : s2_nn_q[1];
    td = (c >= 0) ? s2_den_q[0] : s2_den_q[1];
    ti = (c >= 0) ? s2_inf_q[0] : s2_inf_q[1];
    fn = (cf <= 0) ? s2_fn_q[0]  : s2_fn_q[1];
    fi = (cf <= 0) ? s2_inf_q[0] : s2_inf_q[1];
    hit = s2_ok_q[0] && s2_ok_q[1] && !(c_nf > 0) && !(c_fn > 0)
          && (fi || !(fn < 0))                          // exit not behind start
          && !ti && !(tn < 0)                           // entry not before start
          && (tn < $signed({2'b00, td}));               // entry before frame end
    s3_side_d.hit      = hit;
    s3_side_d.normal_x = (hit && c > 0) ? (s2_neg_q[0] ? 2'b01 : 2'b11) : 2'b00;
    s3_side_d.normal_y = (hit && c < 0) ? (s2_neg_q[1] ? 2'b01 : 2'b11) : 2'b00;
    s3_num_d = hit ? tn[W-1:0] : '0;
    s3_den_d = hit ? td : W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        s1_nn_q[k]  <= s1_nn_d[k];
        s1_fn_q[k]  <= s1_fn_d[k];
        s1_den_q[k] <= s1_den_d[k];
        s1_inf_q[k] <= s1_inf_d[k];
        s1_ok_q[k]  <= s1_ok_d[k];
        s1_neg_q[k] <= s1_neg_d[k];
        s2_nn_q[k]  <= s1_nn_q[k];
        s2_fn_q[k]  <= s1_fn_q[k];
        s2_den_q[k] <= s1_den_q[k];
        s2_inf_q[k] <= s1_inf_q[k];
        s2_ok_q[k]  <= s1_ok_q[k];
        s2_neg_q[k] <= s1_neg_q[k];
      end
      s2_p_q[0] <= xmul(s1_nn_q[0], s1_den_q[1]);
      s2_p_q[1] <= xmul(s1_fn_q[1], s1_den_q[0]);
      s2_p_q[2] <= xmul(s1_nn_q[1], s1_den_q[0]);
      s2_p_q[3] <= xmul(s1_fn_q[0], s1_den_q[1]);
      s2_p_q[4] <= xmul(s1_nn_q[0], s1_den_q[1]);
      s2_p_q[5] <= xmul(s1_nn_q[1], s1_den_q[0]);
      s2_p_q[6] <= xmul(s1_fn_q[0], s1_den_q[1]);
      s2_p_q[7] <= xmul(s1_fn_q[1], s1_den_q[0]);
      s3_side_q <= s3_side_d;
      s3_num_q  <= s3_num_d;
      s3_den_q  <= s3_den_d;
    end
  end

  sbc_div #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TIME_FRAC_BITS(TIME_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s3_valid_q),
    .num_i  (s3_num_q),
    .den_i  (s3_den_q),
    .side_i (s3_side_q),
    .valid_o(div_valid),
    .quot_o (div_quot),
    .side_o (div_side)
  );

  assign m_axis_tvalid = div_valid;
  assign m_axis_tdata  = OW'({div_side.normal_y, div_side.normal_x,
                              div_side.hit ? div_quot : {TIME_FRAC_BITS{1'b0}},
                              div_side.hit});

  logic unused_in;
  assign unused_in = ^s_axis_tdata[IW-1:10*W-4];

endmodule

/* src/sbc_div.sv */
// Pipelined restoring divider: one quotient bit per stage, fraction of num / den.
module sbc_div import sbc_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = CoordWidthDef,
  parameter int unsigned TIME_FRAC_BITS = TimeFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [COORD_WIDTH-1:0]    num_i,
  input  logic [COORD_WIDTH-1:0]    den_i,
  input  sbc_side_t                 side_i,
  output logic                      valid_o,
  output logic [TIME_FRAC_BITS-1:0] quot_o,
  output sbc_side_t                 side_o
);

  localparam int unsigned N = TIME_FRAC_BITS;

  logic                   valid_q [N];
  logic [COORD_WIDTH-1:0] rem_q   [N];
  logic [COORD_WIDTH-1:0] den_q   [N];
  logic [N-1:0]           quot_q  [N];
  sbc_side_t              side_q  [N];

  logic [COORD_WIDTH-1:0] rem_d   [N];
  logic [N-1:0]           quot_d  [N];

  always_comb begin
    logic [COORD_WIDTH:0]   sh;
    logic [COORD_WIDTH-1:0] rin;
    logic [COORD_WIDTH-1:0] dn;
    logic [N-1:0]           qin;
    for (int i = 0; i < N; i++) begin
      rin = (i == 0) ? num_i : rem_q[(i == 0) ? 0 : i-1];
      dn  = (i == 0) ? den_i : den_q[(i == 0) ? 0 : i-1];
      qin = (i == 0) ? '0    : quot_q[(i == 0) ? 0 : i-1];
      sh  = {rin, 1'b0};
      if (sh >= {1'b0, dn}) begin
        rem_d[i]  = COORD_WIDTH'(sh - {1'b0, dn});
        quot_d[i] = {qin[N-2:0], 1'b1};
      end else begin
        rem_d[i]  = sh[COORD_WIDTH-1:0];
        quot_d[i] = {qin[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) valid_q[i] <= 1'b0;
    end else if (en_i) begin
      for (int i = 0; i < N; i++) valid_q[i] <= (i == 0) ? valid_i : valid_q[(i == 0) ? 0 : i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        rem_q[i]  <= rem_d[i];
        quot_q[i] <= quot_d[i];
        den_q[i]  <= (i == 0) ? den_i  : den_q[(i == 0) ? 0 : i-1];
        side_q[i] <= (i == 0) ? side_i : side_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign quot_o  = quot_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

/* src/sbc_chk.sv */
// Port-level checker for the swept box collision core, with its bind.
module sbc_chk import sbc_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = CoordWidthDef,
  parameter int unsigned TIME_FRAC_BITS = TimeFracBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((10*COORD_WIDTH-4+7)/8)*8-1:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((TIME_FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned T = TIME_FRAC_BITS;

  logic       hit;
  logic [1:0] nx, ny;
  assign hit = m_axis_tdata[0];
  assign nx  = m_axis_tdata[T+2:T+1];
  assign ny  = m_axis_tdata[T+4:T+3];

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Stall propagates back to the input within the same cycle.
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // A miss carries all-zero fields.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hit |-> m_axis_tdata[T+4:1] == '0)
    else $error("miss with nonzero fields");

  // At most one normal axis, never the unused code.
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(nx != 2'b00 && ny != 2'b00) && nx != 2'b10 && ny != 2'b10)
    else $error("bad normal");

  logic unused;
  assign unused = ^{s_axis_tvalid, s_axis_tdata};

endmodule

bind swept_box_collision_core sbc_chk #(
  .COORD_WIDTH   (COORD_WIDTH),
  .TIME_FRAC_BITS(TIME_FRAC_BITS)
) u_sbc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* sim/tb_swept_box_collision_core.sv */
// Self-checking testbench for swept_box_collision_core: directed and random box pairs.
`timescale 1ns / 1ps

module tb_swept_box_collision_core;
  import sbc_pkg::*;

  localparam int unsigned CW        = CoordWidthDef;
  localparam int unsigned TF        = TimeFracBitsDef;
  localparam int unsigned IN_BITS   = ((10*CW-4+7)/8)*8;
  localparam int unsigned OUT_BITS  = ((TF+5+7)/8)*8;
  localparam int unsigned HOLD_CYC  = 300;
  localparam int unsigned STALL_MAX = 2000;
  localparam int unsigned DRAIN_CYC = 3 + TF + 20;

  typedef struct {
    logic signed [CW-1:0] ax, ay;
    logic        [CW-2:0] aw, ah;
    logic signed [CW-1:0] vx, vy;
    logic signed [CW-1:0] bx, by;
    logic        [CW-2:0] bw, bh;
  } box_pair_t;

  typedef struct {
    logic          hit;
    logic [TF-1:0] entry;
    logic [1:0]    nx, ny;
  } contact_t;

  // den == 0 marks an infinite value carrying the sign of num
  typedef struct {
    longint num;
    longint den;
  } ratio_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  contact_t contact_q[$];
  bit       idle_en = 1'b1;
  bit       hold_req = 1'b0;
  bit       failed = 1'b0;
  int       stall_cnt = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  swept_box_collision_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Exact rational compare; infinities rank beyond every finite value.
  function automatic int ratio_cmp(ratio_t a, ratio_t b);
    int     ra, rb, sa, sb;
    longint l, r;
    ra = (a.den == 0) ? 2 * ((a.num > 0) - (a.num < 0)) : 0;
    rb = (b.den == 0) ? 2 * ((b.num > 0) - (b.num < 0)) : 0;
    if (ra != rb) return (ra < rb) ? -1 : 1;
    if (ra != 0) return 0;
    sa = (a.num > 0) - (a.num < 0);
    sb = (b.num > 0) - (b.num < 0);
    if (sa != sb) return (sa < sb) ? -1 : 1;
    if (sa == 0) return 0;
    l = (a.num < 0 ? -a.num : a.num) * b.den;
    r = (b.num < 0 ? -b.num : b.num) * a.den;
    if (l == r) return 0;
    if (sa > 0) return (l < r) ? -1 : 1;
    return (l < r) ? 1 : -1;
  endfunction

  // Entry and exit times of one axis; zero on a still axis that misses the slab.
  function automatic bit axis_slab(longint a, longint asz, longint v, longint b,
                                   longint bsz, output ratio_t t_in, output ratio_t t_out);
    longint dn, df;
    dn = b - a - asz;
    df = b + bsz - a;
    t_in  = '{-1, 0};
    t_out = '{1, 0};
    if (v > 0) begin
      t_in  = '{dn, v};
      t_out = '{df, v};
    end else if (v < 0) begin
      t_in  = '{-df, -v};
      t_out = '{-dn, -v};
    end else if (!(dn <= 0 && df >= 0)) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic contact_t sweep_contact(box_pair_t p);
    contact_t res;
    ratio_t   nx, fx, ny, fy, t, tf;
    int       c;
    longint   q;
    res = '{1'b0, '0, 2'b00, 2'b00};
    if (!axis_slab(p.ax, p.aw, p.vx, p.bx, p.bw, nx, fx)) return res;
    if (!axis_slab(p.ay, p.ah, p.vy, p.by, p.bh, ny, fy)) return res;
    if (ratio_cmp(nx, fy) > 0 || ratio_cmp(ny, fx) > 0) return res;
    c  = ratio_cmp(nx, ny);
    t  = (c >= 0) ? nx : ny;
    tf = (ratio_cmp(fx, fy) <= 0) ? fx : fy;
    if (ratio_cmp(tf, '{0, 1}) < 0) return res;
    if (ratio_cmp(t, '{0, 1}) < 0 || ratio_cmp(t, '{1, 1}) >= 0) return res;
    q = (t.num <<< TF) / t.den;
    res.hit   = 1'b1;
    res.entry = q[TF-1:0];
    // normal points against the motion on the later axis; tie stays zero
    if (c > 0) res.nx = (p.vx < 0) ? 2'b01 : 2'b11;
    else if (c < 0) res.ny = (p.vy < 0) ? 2'b01 : 2'b11;
    return res;
  endfunction

  function automatic box_pair_t pair(int ax, int ay, int aw, int ah, int vx, int vy,
                                     int bx, int by, int bw, int bh);
    box_pair_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.aw = (CW-1)'(aw); p.ah = (CW-1)'(ah);
    p.vx = CW'(vx); p.vy = CW'(vy);
    p.bx = CW'(bx); p.by = CW'(by); p.bw = (CW-1)'(bw); p.bh = (CW-1)'(bh);
    return p;
  endfunction

  // Offer one item, hold it until taken, queue its expected contact.
  task automatic send_pair(box_pair_t p);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, p.bh, p.bw, p.by, p.bx, p.vy, p.vx, p.ah, p.aw, p.ay, p.ax};
    do @(posedge clk_i); while (!s_axis_tready);
    contact_q.push_back(sweep_contact(p));
  endtask

  function automatic box_pair_t noise_pair();
    return pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Pair aimed so that A mostly sweeps into B within the frame.
  function automatic box_pair_t aimed_pair();
    int bx, by, ax, ay, aw, ah, vx, vy;
    bx = $urandom_range(0, 16000) - 8000;
    by = $urandom_range(0, 16000) - 8000;
    aw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 2000);
    ah = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 2000);
    ax = bx + $urandom_range(0, 12000) - 6000;
    ay = by + $urandom_range(0, 12000) - 6000;
    vx = (bx - ax) * int'($urandom_range(2, 8)) / 4 + int'($urandom_range(0, 400)) - 200;
    vy = (by - ay) * int'($urandom_range(2, 8)) / 4 + int'($urandom_range(0, 400)) - 200;
    case ($urandom_range(0, 7))
      0: vx = 0;
      1: vy = 0;
      2: vy = vx;
      default: ;
    endcase
    return pair(ax, ay, aw, ah, vx, vy, bx, by,
                $urandom_range(0, 2000), $urandom_range(0, 2000));
  endfunction

  task automatic test_directed();
    send_pair(pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair(0, 0, 16, 16, 64, 0, 40, 0, 16, 16));     // enter from the left
    send_pair(pair(100, 0, 16, 16, -64, 0, 40, 0, 16, 16));  // enter from the right
    send_pair(pair(0, 0, 16, 16, 0, 64, 0, 40, 16, 16));     // enter from above
    send_pair(pair(0, 100, 16, 16, 0, -64, 0, 40, 16, 16));  // enter from below
    send_pair(pair(0, 0, 16, 16, 32, 32, 24, 24, 16, 16));   // corner tie, zero normal
    send_pair(pair(0, 0, 16, 16, 10, 0, 8, 0, 16, 16));      // overlapping at start
    send_pair(pair(0, 0, 16, 16, 0, 40, 16, 30, 16, 16));    // still x, on slab edge
    send_pair(pair(0, 0, 16, 16, 0, 40, 17, 30, 16, 16));    // still x, outside slab
    send_pair(pair(0, 0, 16, 16, 0, 0, 40, 40, 16, 16));     // no motion at all
    send_pair(pair(0, 0, 16, 16, 24, 0, 40, 0, 16, 16));     // touches at t = 1
    send_pair(pair(0, 0, 16, 16, 24, 0, 16, 0, 16, 16));     // touches at t = 0
    send_pair(pair(0, 0, 16, 16, 24, 0, -80, 0, 16, 16));    // moving away
    send_pair(pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair(32767, 32767, 32767, 32767, -32768, -32768,
                   -32768, -32768, 32767, 32767));
    send_pair(pair(-32768, 32767, 0, 32767, 32767, -32768, 32767, -32768, 32767, 0));
    send_pair(pair(32767, -32768, 32767, 0, -32768, 32767, -32768, 32767, 0, 32767));
    send_pair(pair(0, 0, 0, 0, 1, 1, 1, 1, 0, 0));
    send_pair(pair(0, 0, 0, 0, -1, 32767, -1, 32766, 0, 0));
  endtask

  task automatic test_random(int n);
    repeat (n) send_pair(($urandom_range(0, 3) == 0) ? noise_pair() : aimed_pair());
  endtask

  // Stall the result side long enough for the pipeline to fill and block input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (60) send_pair(aimed_pair());
  endtask

  task automatic test_no_idle(int n);
    idle_en = 1'b0;
    test_random(n);
  endtask

  // Result side: random stall bursts, plus the long hold when asked.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_en && rst_ni && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest pending contact.
  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = contact_q.pop_front();
        if (m_axis_tdata[0] !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, m_axis_tdata[0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[TF:1] !== want.entry) begin
          $display("%0t: entry_time expected %h actual %h", $time, want.entry,
                   m_axis_tdata[TF:1]);
          failed = 1'b1;
        end
        if (m_axis_tdata[TF+2:TF+1] !== want.nx) begin
          $display("%0t: normal_x expected %b actual %b", $time, want.nx,
                   m_axis_tdata[TF+2:TF+1]);
          failed = 1'b1;
        end
        if (m_axis_tdata[TF+4:TF+3] !== want.ny) begin
          $display("%0t: normal_y expected %b actual %b", $time, want.ny,
                   m_axis_tdata[TF+4:TF+3]);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("FAIL swept_box_collision_core");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(300);
    test_no_idle(275);
    s_axis_tvalid <= 1'b0;
    wait (contact_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (!failed && contact_q.size() == 0) begin
      $display("PASS swept_box_collision_core");
    end else begin
      $display("FAIL swept_box_collision_core");
    end
    $finish;
  end

endmodule
